>>> rtl/breaker_charging_overcurrent_relay_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the charging overcurrent relay
// Shared check forms; every check is clocked by i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BREAKER_CHARGING_OVERCURRENT_RELAY_TOP_DEFINES_SVH
`define BREAKER_CHARGING_OVERCURRENT_RELAY_TOP_DEFINES_SVH

// same-cycle implication
`define BCOR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCOR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bcor_pkg.sv
// ----------------------------------------------------------------------------
// Charging overcurrent relay package
// Field widths, register indexes, reset values and the element state types.
// ----------------------------------------------------------------------------
package bcor_pkg;

    localparam int CUR_W      = 16;
    localparam int TIME_W     = 32;
    localparam int BRK_W      = 2;
    localparam int THR_W      = 15;
    localparam int DLY_W      = 16;
    localparam int MASK_W     = 12;
    localparam int MASK_IDX_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int KINDS      = 3;
    localparam int TIE_COUNT  = 2;

    localparam int SUM_W      = CUR_W + 2;
    localparam int SQ_W       = 2 * CUR_W - 1;
    localparam int MAG_W      = 2 * CUR_W;
    localparam int ZSQ_W      = 2 * SUM_W - 1;
    localparam int THR_SQ_W   = 2 * THR_W;
    localparam int THR_SQ9_W  = THR_SQ_W + 4;

    // element kinds
    localparam int KIND_ONE  = 0;
    localparam int KIND_TWO  = 1;
    localparam int KIND_ZERO = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_ONE_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_TWO_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SEQ_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_ONE_DLY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_TWO_DLY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SEQ_DLY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK   = 3'd6;

    // reset values
    localparam int RST_THR_ONE  = 4096;
    localparam int RST_THR_TWO  = 3277;
    localparam int RST_THR_ZERO = 1229;
    localparam logic [THR_SQ_W-1:0]  RST_THR_ONE_SQ   = THR_SQ_W'(RST_THR_ONE * RST_THR_ONE);
    localparam logic [THR_SQ_W-1:0]  RST_THR_TWO_SQ   = THR_SQ_W'(RST_THR_TWO * RST_THR_TWO);
    localparam logic [THR_SQ_W-1:0]  RST_THR_ZERO_SQ  =
        THR_SQ_W'(RST_THR_ZERO * RST_THR_ZERO);
    localparam logic [THR_SQ9_W-1:0] RST_THR_ZERO_SQ9 =
        THR_SQ9_W'(9 * RST_THR_ZERO * RST_THR_ZERO);
    localparam logic [DLY_W-1:0] RST_DLY_ONE  = 16'd200;
    localparam logic [DLY_W-1:0] RST_DLY_TWO  = 16'd400;
    localparam logic [DLY_W-1:0] RST_DLY_ZERO = 16'd300;
    localparam logic [MASK_W-1:0] RST_MASK    = 12'd0;

    typedef struct packed {
        logic [TIME_W-1:0] start_ms;
        logic              active;
        logic              pickup;
        logic              trip;
    } t_elem;

    typedef t_elem [KINDS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

endpackage

>>> rtl/bcor_if.sv
// ----------------------------------------------------------------------------
// Charging overcurrent relay channels
// Input item, result item and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface bcor_in_if
    import bcor_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [BRK_W-1:0]        breaker_index;
    logic [TIME_W-1:0]       now_ms;
    logic signed [CUR_W-1:0] phase_a_real;
    logic signed [CUR_W-1:0] phase_a_imag;
    logic signed [CUR_W-1:0] phase_b_real;
    logic signed [CUR_W-1:0] phase_b_imag;
    logic signed [CUR_W-1:0] phase_c_real;
    logic signed [CUR_W-1:0] phase_c_imag;

    modport source (
        output valid, breaker_index, now_ms, phase_a_real, phase_a_imag,
               phase_b_real, phase_b_imag, phase_c_real, phase_c_imag,
        input  ready
    );
    modport sink (
        input  valid, breaker_index, now_ms, phase_a_real, phase_a_imag,
               phase_b_real, phase_b_imag, phase_c_real, phase_c_imag,
        output ready
    );
endinterface

interface bcor_out_if
    import bcor_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [BRK_W-1:0] breaker_echo;
    logic             pickup_stage_one;
    logic             pickup_stage_two;
    logic             pickup_zero_seq;
    logic             trip_stage_one;
    logic             trip_stage_two;
    logic             trip_zero_seq;

    modport source (
        output valid, breaker_echo, pickup_stage_one, pickup_stage_two,
               pickup_zero_seq, trip_stage_one, trip_stage_two, trip_zero_seq,
        input  ready
    );
    modport sink (
        input  valid, breaker_echo, pickup_stage_one, pickup_stage_two,
               pickup_zero_seq, trip_stage_one, trip_stage_two, trip_zero_seq,
        output ready
    );
endinterface

interface bcor_cfg_if
    import bcor_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

>>> rtl/bcor_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bcor_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/breaker_charging_overcurrent_relay_top.sv
// ----------------------------------------------------------------------------
// Charging overcurrent relay, top level
// Stage I, stage II and zero-sequence definite-time elements per breaker.
// ----------------------------------------------------------------------------
// Takes one breaker's phasors per cycle while the output is not stalled
// and returns that breaker's latched pickup and trip flags. The four
// stages are: sum and square the components, form magnitudes and compare,
// read-modify-write of the breaker's row in the state RAM, output register.
// Back-to-back items on the same breaker are forwarded from the last row
// written, so the rate stays one item per cycle without output stalls.
// Rows that were never written read as cleared state through per-row valid
// bits, so no clearing pass follows reset. The register channel is always
// ready; threshold squares are formed as a register is written.
module breaker_charging_overcurrent_relay_top
    import bcor_pkg::*;
#(
    parameter int NUM_BREAKERS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcor_in_if.sink    i_in,
    bcor_out_if.source o_out,
    bcor_cfg_if.sink   i_cfg
);

    `include "breaker_charging_overcurrent_relay_top_defines.svh"

    localparam int ADDR_W = NUM_BREAKERS > 1 ? $clog2(NUM_BREAKERS) : 1;

    // ---------------- configuration ----------------
    logic [THR_SQ_W-1:0]  r_thr_one_sq, r_thr_two_sq, r_thr_zero_sq;
    logic [THR_SQ9_W-1:0] r_thr_zero_sq9;
    logic [DLY_W-1:0]     r_dly [KINDS];
    logic [MASK_W-1:0]    r_mask;

    logic [THR_W-1:0]     cfg_thr;
    logic [THR_W+3:0]     cfg_thr9;
    logic [THR_SQ_W-1:0]  cfg_thr_sq;
    logic [THR_SQ9_W-1:0] cfg_thr_sq9;
    logic                 cfg_we;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    always_comb begin
        cfg_thr     = i_cfg.reg_data[THR_W-1:0];
        cfg_thr9    = {1'b0, cfg_thr, 3'b000} + (THR_W+4)'(cfg_thr);
        cfg_thr_sq  = THR_SQ_W'(cfg_thr) * THR_SQ_W'(cfg_thr);
        cfg_thr_sq9 = THR_SQ9_W'(cfg_thr) * THR_SQ9_W'(cfg_thr9);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_one_sq     <= RST_THR_ONE_SQ;
            r_thr_two_sq     <= RST_THR_TWO_SQ;
            r_thr_zero_sq    <= RST_THR_ZERO_SQ;
            r_thr_zero_sq9   <= RST_THR_ZERO_SQ9;
            r_dly[KIND_ONE]  <= RST_DLY_ONE;
            r_dly[KIND_TWO]  <= RST_DLY_TWO;
            r_dly[KIND_ZERO] <= RST_DLY_ZERO;
            r_mask           <= RST_MASK;
        end else if (cfg_we) begin
            case (i_cfg.reg_index)
                REG_STAGE_ONE_THR: r_thr_one_sq <= cfg_thr_sq;
                REG_STAGE_TWO_THR: r_thr_two_sq <= cfg_thr_sq;
                REG_ZERO_SEQ_THR: begin
                    r_thr_zero_sq  <= cfg_thr_sq;
                    r_thr_zero_sq9 <= cfg_thr_sq9;
                end
                REG_STAGE_ONE_DLY: r_dly[KIND_ONE]  <= i_cfg.reg_data[DLY_W-1:0];
                REG_STAGE_TWO_DLY: r_dly[KIND_TWO]  <= i_cfg.reg_data[DLY_W-1:0];
                REG_ZERO_SEQ_DLY:  r_dly[KIND_ZERO] <= i_cfg.reg_data[DLY_W-1:0];
                REG_ENABLE_MASK:   r_mask <= i_cfg.reg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic advance;
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_out_vld;

    assign advance    = !r_out_vld || o_out.ready;
    assign i_in.ready = advance;

    // ---------------- stage 1: sums and component squares ----------------
    logic [BRK_W-1:0]        r_s1_b;
    logic [TIME_W-1:0]       r_s1_now;
    logic signed [CUR_W-1:0] r_s1_re [3];
    logic signed [CUR_W-1:0] r_s1_im [3];

    logic signed [SUM_W-1:0]   s1_sum_re, s1_sum_im;
    logic signed [2*CUR_W-1:0] s1_prod_re [3];
    logic signed [2*CUR_W-1:0] s1_prod_im [3];

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_b   <= i_in.breaker_index;
            r_s1_now <= i_in.now_ms;
            r_s1_re[0] <= i_in.phase_a_real;
            r_s1_im[0] <= i_in.phase_a_imag;
            r_s1_re[1] <= i_in.phase_b_real;
            r_s1_im[1] <= i_in.phase_b_imag;
            r_s1_re[2] <= i_in.phase_c_real;
            r_s1_im[2] <= i_in.phase_c_imag;
        end
    end

    always_comb begin
        s1_sum_re = SUM_W'(r_s1_re[0]) + SUM_W'(r_s1_re[1]) + SUM_W'(r_s1_re[2]);
        s1_sum_im = SUM_W'(r_s1_im[0]) + SUM_W'(r_s1_im[1]) + SUM_W'(r_s1_im[2]);
        for (int k = 0; k < 3; k++) begin
            s1_prod_re[k] = r_s1_re[k] * r_s1_re[k];
            s1_prod_im[k] = r_s1_im[k] * r_s1_im[k];
        end
    end

    // ---------------- stage 2: magnitudes, stage compares ----------------
    logic [BRK_W-1:0]        r_s2_b;
    logic [TIME_W-1:0]       r_s2_now;
    logic [SQ_W-1:0]         r_s2_sq_re [3];
    logic [SQ_W-1:0]         r_s2_sq_im [3];
    logic signed [SUM_W-1:0] r_s2_sum_re, r_s2_sum_im;

    logic [MAG_W-1:0]          s2_mag [3];
    logic                      s2_p1, s2_p2;
    logic signed [2*SUM_W-1:0] s2_zprod_re, s2_zprod_im;
    logic [ZSQ_W-1:0]          s2_zsq;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2_b      <= r_s1_b;
            r_s2_now    <= r_s1_now;
            r_s2_sum_re <= s1_sum_re;
            r_s2_sum_im <= s1_sum_im;
            for (int k = 0; k < 3; k++) begin
                r_s2_sq_re[k] <= s1_prod_re[k][SQ_W-1:0];
                r_s2_sq_im[k] <= s1_prod_im[k][SQ_W-1:0];
            end
        end
    end

    always_comb begin
        s2_p1 = 1'b0;
        s2_p2 = 1'b0;
        for (int k = 0; k < 3; k++) begin
            s2_mag[k] = MAG_W'(r_s2_sq_re[k]) + MAG_W'(r_s2_sq_im[k]);
            if (s2_mag[k] > MAG_W'(r_thr_one_sq)) s2_p1 = 1'b1;
            if (s2_mag[k] > MAG_W'(r_thr_two_sq)) s2_p2 = 1'b1;
        end
        s2_zprod_re = r_s2_sum_re * r_s2_sum_re;
        s2_zprod_im = r_s2_sum_im * r_s2_sum_im;
        s2_zsq = ZSQ_W'(s2_zprod_re[ZSQ_W-2:0]) + ZSQ_W'(s2_zprod_im[ZSQ_W-2:0]);
    end

    // ---------------- stage 3: read-modify-write of the breaker row ----------------
    logic [BRK_W-1:0]  r_s3_b;
    logic [TIME_W-1:0] r_s3_now;
    logic              r_s3_p1, r_s3_p2;
    logic [ZSQ_W-1:0]  r_s3_zsq;

    logic [NUM_BREAKERS-1:0] r_row_vld;
    logic                    r_wb_vld;
    logic [ADDR_W-1:0]       r_wb_addr;
    t_row                    r_wb_row;

    logic [ROW_W-1:0]  ram_rd_data;
    logic              ram_rd_en, wr_en;
    logic [ADDR_W-1:0] s2_addr, s3_addr;
    logic              s3_in_range, s3_tie, s3_pz;
    logic [KINDS-1:0]  s3_pick, s3_en;
    t_row              cur_row, n_row;

    function automatic t_elem run_elem(
        input t_elem             cur,
        input logic              en,
        input logic              picked,
        input logic [TIME_W-1:0] now,
        input logic [DLY_W-1:0]  dly
    );
        t_elem             nxt;
        logic [TIME_W-1:0] elapsed;
        nxt = cur;
        elapsed = '0;
        if (en) begin
            if (!picked) begin
                nxt.active = 1'b0;
            end else begin
                nxt.pickup = 1'b1;
                if (!cur.active) begin
                    nxt.active   = 1'b1;
                    nxt.start_ms = now;
                end
                elapsed = now - nxt.start_ms;
                if (elapsed >= TIME_W'(dly)) begin
                    nxt.trip     = 1'b1;
                    nxt.active   = 1'b0;
                    nxt.start_ms = '0;
                end
            end
        end
        return nxt;
    endfunction

    assign s2_addr   = ADDR_W'(r_s2_b);
    assign s3_addr   = ADDR_W'(r_s3_b);
    assign ram_rd_en = advance && r_s2_vld;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s3_b   <= r_s2_b;
            r_s3_now <= r_s2_now;
            r_s3_p1  <= s2_p1;
            r_s3_p2  <= s2_p2;
            r_s3_zsq <= s2_zsq;
        end
    end

    always_comb begin
        s3_in_range = (int'(r_s3_b) < NUM_BREAKERS);
        s3_tie      = ({1'b0, r_s3_b} < (BRK_W+1)'(TIE_COUNT));
        s3_pz       = s3_tie ? (r_s3_zsq > ZSQ_W'(r_thr_zero_sq9))
                             : (r_s3_zsq > ZSQ_W'(r_thr_zero_sq));
        s3_pick[KIND_ONE]  = r_s3_p1;
        s3_pick[KIND_TWO]  = r_s3_p2;
        s3_pick[KIND_ZERO] = s3_pz;

        // newest row: last write-back, else RAM, else cleared
        if (r_wb_vld && r_wb_addr == s3_addr) begin
            cur_row = r_wb_row;
        end else if (r_row_vld[s3_addr]) begin
            cur_row = t_row'(ram_rd_data);
        end else begin
            cur_row = '0;
        end

        // enable bits past the mask read as off
        for (int k = 0; k < KINDS; k++) begin
            s3_en[k] = (k * NUM_BREAKERS + int'(r_s3_b) < MASK_W) &&
                       r_mask[MASK_IDX_W'(k * NUM_BREAKERS + int'(r_s3_b))];
            n_row[k] = run_elem(cur_row[k], s3_en[k], s3_pick[k], r_s3_now, r_dly[k]);
        end
    end

    assign wr_en = advance && r_s3_vld && s3_in_range;

    bcor_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BREAKERS)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (s3_addr),
        .i_wr_data (ROW_W'(n_row)),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (s2_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_wb_vld  <= 1'b0;
        end else if (wr_en) begin
            r_row_vld[s3_addr] <= 1'b1;
            r_wb_vld           <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wb_addr <= s3_addr;
            r_wb_row  <= n_row;
        end
    end

    // ---------------- output register ----------------
    logic [BRK_W-1:0] r_out_b;
    logic [KINDS-1:0] r_out_pick, r_out_trip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_s1_vld  <= i_in.valid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_out_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_b <= r_s3_b;
            for (int k = 0; k < KINDS; k++) begin
                r_out_pick[k] <= s3_in_range && n_row[k].pickup;
                r_out_trip[k] <= s3_in_range && n_row[k].trip;
            end
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.breaker_echo     = r_out_b;
    assign o_out.pickup_stage_one = r_out_pick[KIND_ONE];
    assign o_out.pickup_stage_two = r_out_pick[KIND_TWO];
    assign o_out.pickup_zero_seq  = r_out_pick[KIND_ZERO];
    assign o_out.trip_stage_one   = r_out_trip[KIND_ONE];
    assign o_out.trip_stage_two   = r_out_trip[KIND_TWO];
    assign o_out.trip_zero_seq    = r_out_trip[KIND_ZERO];

    // ---------------- assertions ----------------
    `BCOR_ASSERT_IMP(a_stall_holds_input, r_out_vld && !o_out.ready, !i_in.ready,
        "input taken while the result register is stalled")
    `BCOR_ASSERT_IMP(a_write_in_range, wr_en, s3_in_range,
        "state row written for a breaker beyond the configured count")
    `BCOR_ASSERT_IMP(a_pickup_sticky, wr_en,
        (!cur_row[KIND_ONE].pickup || n_row[KIND_ONE].pickup) &&
        (!cur_row[KIND_TWO].pickup || n_row[KIND_TWO].pickup) &&
        (!cur_row[KIND_ZERO].pickup || n_row[KIND_ZERO].pickup),
        "latched pickup dropped on write-back")
    `BCOR_ASSERT_IMP(a_trip_implies_pickup, r_out_vld,
        (!r_out_trip[KIND_ONE] || r_out_pick[KIND_ONE]) &&
        (!r_out_trip[KIND_TWO] || r_out_pick[KIND_TWO]) &&
        (!r_out_trip[KIND_ZERO] || r_out_pick[KIND_ZERO]),
        "trip reported without pickup")
    `BCOR_ASSERT_NXT(a_forward_tracks_write, wr_en,
        r_wb_vld && r_wb_addr == $past(s3_addr) && r_row_vld[$past(s3_addr)],
        "forwarding register does not hold the last written row")

endmodule

>>> bench/breaker_charging_overcurrent_relay_checker.sv
// ----------------------------------------------------------------------------
// Charging overcurrent relay checker
// Watches the item, result and register channels. It keeps its own copy of
// the thresholds, delays, enables and per-element timers, predicts the
// latched flags of every accepted item and compares each result in order.
// ----------------------------------------------------------------------------
module breaker_charging_overcurrent_relay_checker
    import bcor_pkg::*;
#(
    parameter int NUM_BREAKERS = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bcor_in_if   i_in_mon,
    bcor_out_if  i_out_mon,
    bcor_cfg_if  i_cfg_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_trips
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ELEMENTS    = KINDS * NUM_BREAKERS;
    localparam int PRINT_LIMIT = 40;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [BRK_W-1:0] breaker;
        logic             pickup_one;
        logic             pickup_two;
        logic             pickup_zero;
        logic             trip_one;
        logic             trip_two;
        logic             trip_zero;
    } relay_flags_t;

    logic [THR_W-1:0]  thr_one;
    logic [THR_W-1:0]  thr_two;
    logic [THR_W-1:0]  thr_zero;
    logic [DLY_W-1:0]  dly_one;
    logic [DLY_W-1:0]  dly_two;
    logic [DLY_W-1:0]  dly_zero;
    logic [MASK_W-1:0] enable_mask;

    logic [TIME_W-1:0] timer_origin  [ELEMENTS];
    logic              timer_running [ELEMENTS];
    logic              pickup_held   [ELEMENTS];
    logic              trip_held     [ELEMENTS];

    relay_flags_t flags_due [$];
    int           fail_count    = 0;
    int           checked_count = 0;
    int           trip_count    = 0;

    function automatic void restore_reset_state();
        thr_one     = THR_W'(RST_THR_ONE);
        thr_two     = THR_W'(RST_THR_TWO);
        thr_zero    = THR_W'(RST_THR_ZERO);
        dly_one     = RST_DLY_ONE;
        dly_two     = RST_DLY_TWO;
        dly_zero    = RST_DLY_ZERO;
        enable_mask = RST_MASK;
        for (int e = 0; e < ELEMENTS; e++) begin
            timer_origin[e]  = '0;
            timer_running[e] = 1'b0;
            pickup_held[e]   = 1'b0;
            trip_held[e]     = 1'b0;
        end
        flags_due.delete();
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] index,
                                           input logic [CFG_DATA_W-1:0] data);
        case (index)
            REG_STAGE_ONE_THR: thr_one     = data[THR_W-1:0];
            REG_STAGE_TWO_THR: thr_two     = data[THR_W-1:0];
            REG_ZERO_SEQ_THR:  thr_zero    = data[THR_W-1:0];
            REG_STAGE_ONE_DLY: dly_one     = data[DLY_W-1:0];
            REG_STAGE_TWO_DLY: dly_two     = data[DLY_W-1:0];
            REG_ZERO_SEQ_DLY:  dly_zero    = data[DLY_W-1:0];
            REG_ENABLE_MASK:   enable_mask = data[MASK_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic u64_t square_of(input longint value);
        u64_t mag;
        mag = (value < 0) ? u64_t'(-value) : u64_t'(value);
        return mag * mag;
    endfunction

    // definite-time element: latch pickup, start an idle timer, trip on expiry
    function automatic void update_element(input int e, input logic picked,
                                           input logic [TIME_W-1:0] now,
                                           input logic [DLY_W-1:0] delay);
        logic [TIME_W-1:0] elapsed;
        if (!picked) begin
            timer_running[e] = 1'b0;
        end else begin
            pickup_held[e] = 1'b1;
            if (!timer_running[e]) begin
                timer_running[e] = 1'b1;
                timer_origin[e]  = now;
            end
            elapsed = now - timer_origin[e];
            if (elapsed >= TIME_W'(delay)) begin
                trip_held[e]     = 1'b1;
                timer_running[e] = 1'b0;
                timer_origin[e]  = '0;
            end
        end
    endfunction

    function automatic relay_flags_t predict_flags(
        input logic [BRK_W-1:0] brk, input logic [TIME_W-1:0] now,
        input longint a_re, input longint a_im, input longint b_re,
        input longint b_im, input longint c_re, input longint c_im);
        longint       re [3];
        longint       im [3];
        u64_t         phase_mag;
        u64_t         limit_one;
        u64_t         limit_two;
        u64_t         limit_zero;
        u64_t         residual_mag;
        logic         over_one;
        logic         over_two;
        logic         over_zero;
        int           e_one;
        int           e_two;
        int           e_zero;
        relay_flags_t flags;
        // a breaker past the configured count changes nothing and reports no flags
        flags         = '0;
        flags.breaker = brk;
        if (int'(brk) >= NUM_BREAKERS) return flags;
        re = '{a_re, b_re, c_re};
        im = '{a_im, b_im, c_im};
        over_one   = 1'b0;
        over_two   = 1'b0;
        limit_one  = u64_t'(thr_one) * u64_t'(thr_one);
        limit_two  = u64_t'(thr_two) * u64_t'(thr_two);
        limit_zero = u64_t'(thr_zero) * u64_t'(thr_zero);
        for (int k = 0; k < 3; k++) begin
            phase_mag = square_of(re[k]) + square_of(im[k]);
            if (phase_mag > limit_one) over_one = 1'b1;
            if (phase_mag > limit_two) over_two = 1'b1;
        end
        residual_mag = square_of(re[0] + re[1] + re[2]) + square_of(im[0] + im[1] + im[2]);
        // ties compare a third of the residual, so scale the threshold by nine
        if (int'(brk) < TIE_COUNT) begin
            over_zero = residual_mag > u64_t'(9) * limit_zero;
        end else begin
            over_zero = residual_mag > limit_zero;
        end

        e_one  = KIND_ONE * NUM_BREAKERS + int'(brk);
        e_two  = KIND_TWO * NUM_BREAKERS + int'(brk);
        e_zero = KIND_ZERO * NUM_BREAKERS + int'(brk);
        if (enable_mask[e_one])  update_element(e_one, over_one, now, dly_one);
        if (enable_mask[e_two])  update_element(e_two, over_two, now, dly_two);
        if (enable_mask[e_zero]) update_element(e_zero, over_zero, now, dly_zero);

        flags.pickup_one  = pickup_held[e_one];
        flags.pickup_two  = pickup_held[e_two];
        flags.pickup_zero = pickup_held[e_zero];
        flags.trip_one    = trip_held[e_one];
        flags.trip_two    = trip_held[e_two];
        flags.trip_zero   = trip_held[e_zero];
        return flags;
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < PRINT_LIMIT) begin
            $display("[%0t] relay result %0d: %s", $realtime, checked_count, what);
        end
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [BRK_W-1:0] got,
                               input logic [BRK_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
        end
    endtask

    always @(posedge i_clk) begin
        relay_flags_t seen;
        relay_flags_t want;
        if (!i_rst_n) begin
            restore_reset_state();
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                apply_register(i_cfg_mon.reg_index, i_cfg_mon.reg_data);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                seen.breaker     = i_out_mon.breaker_echo;
                seen.pickup_one  = i_out_mon.pickup_stage_one;
                seen.pickup_two  = i_out_mon.pickup_stage_two;
                seen.pickup_zero = i_out_mon.pickup_zero_seq;
                seen.trip_one    = i_out_mon.trip_stage_one;
                seen.trip_two    = i_out_mon.trip_stage_two;
                seen.trip_zero   = i_out_mon.trip_zero_seq;
                if (flags_due.size() == 0) begin
                    report_mismatch("result arrived with no item waiting for it");
                end else begin
                    want = flags_due.pop_front();
                    check_field("breaker_echo", seen.breaker, want.breaker);
                    check_field("pickup_stage_one", BRK_W'(seen.pickup_one),
                                BRK_W'(want.pickup_one));
                    check_field("pickup_stage_two", BRK_W'(seen.pickup_two),
                                BRK_W'(want.pickup_two));
                    check_field("pickup_zero_seq", BRK_W'(seen.pickup_zero),
                                BRK_W'(want.pickup_zero));
                    check_field("trip_stage_one", BRK_W'(seen.trip_one),
                                BRK_W'(want.trip_one));
                    check_field("trip_stage_two", BRK_W'(seen.trip_two),
                                BRK_W'(want.trip_two));
                    check_field("trip_zero_seq", BRK_W'(seen.trip_zero),
                                BRK_W'(want.trip_zero));
                    checked_count++;
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                want = predict_flags(i_in_mon.breaker_index, i_in_mon.now_ms,
                                     longint'(i_in_mon.phase_a_real),
                                     longint'(i_in_mon.phase_a_imag),
                                     longint'(i_in_mon.phase_b_real),
                                     longint'(i_in_mon.phase_b_imag),
                                     longint'(i_in_mon.phase_c_real),
                                     longint'(i_in_mon.phase_c_imag));
                if (want.trip_one || want.trip_two || want.trip_zero) trip_count++;
                flags_due.push_back(want);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= flags_due.size();
        o_checked    <= checked_count;
        o_trips      <= trip_count;
    end

endmodule

>>> bench/breaker_charging_overcurrent_relay_top_tb.sv
// ----------------------------------------------------------------------------
// Charging overcurrent relay testbench
// Drives phasor items and register writes into the relay, stalls both sides
// at random, and leaves prediction and comparison to the checker. Directed
// items cover disabled elements, threshold edges, tie and section residual
// limits, dropout and clock wrap; random phases follow under many settings.
// ----------------------------------------------------------------------------
module breaker_charging_overcurrent_relay_top_tb
    import bcor_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BREAKERS       = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 160;
    localparam int MAX_GAP        = 14;
    localparam int Q12_MAX        = 32767;
    localparam int Q12_MIN        = -32768;

    // one index past the register list, written to show it is ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bcor_in_if  in_ch ();
    bcor_out_if out_ch ();
    bcor_cfg_if cfg_ch ();

    int                fail_count;
    int                pending;
    int                checked;
    int                trips;
    int                items_sent    = 0;
    int                settings_used = 0;
    int                idle_cycles   = 0;
    bit                calm_mode     = 1'b0;
    logic [TIME_W-1:0] wall_ms       = '0;
    int                step_max      = 5;
    int                thr_now [3]   = '{RST_THR_ONE, RST_THR_TWO, RST_THR_ZERO};

    breaker_charging_overcurrent_relay_top #(
        .NUM_BREAKERS(BREAKERS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    breaker_charging_overcurrent_relay_checker #(
        .NUM_BREAKERS(BREAKERS)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_ch),
        .i_out_mon   (out_ch),
        .i_cfg_mon   (cfg_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_trips     (trips)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic signed [CUR_W-1:0] to_q12(input int value);
        if (value > Q12_MAX) return CUR_W'(Q12_MAX);
        if (value < Q12_MIN) return CUR_W'(Q12_MIN);
        return CUR_W'(value);
    endfunction

    function automatic int jitter(input int spread);
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    function automatic int rand_q12();
        return int'($urandom_range(0, 65535)) + Q12_MIN;
    endfunction

    // fault level for a run, placed around the thresholds now in force
    function automatic int pick_scale();
        case ($urandom_range(0, 6))
            0: return 0;
            1: return thr_now[1] / 2;
            2: return (thr_now[0] + thr_now[1]) / 2;
            3: return thr_now[0] + thr_now[0] / 4 + 1;
            4: return thr_now[2] + int'($urandom_range(0, thr_now[2] / 2 + 1));
            5: return 3 * thr_now[2] + int'($urandom_range(0, thr_now[2] + 1));
            default: return int'($urandom_range(0, Q12_MAX));
        endcase
    endfunction

    task automatic send_phasor(input int brk, input logic [TIME_W-1:0] now,
                               input int a_re, input int a_im, input int b_re,
                               input int b_im, input int c_re, input int c_im);
        int gap;
        gap = calm_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.breaker_index <= BRK_W'(brk);
        in_ch.now_ms        <= now;
        in_ch.phase_a_real  <= to_q12(a_re);
        in_ch.phase_a_imag  <= to_q12(a_im);
        in_ch.phase_b_real  <= to_q12(b_re);
        in_ch.phase_b_imag  <= to_q12(b_im);
        in_ch.phase_c_real  <= to_q12(c_re);
        in_ch.phase_c_imag  <= to_q12(c_im);
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // hold the sender until every expected result is back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= index;
        cfg_ch.reg_data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic program_relay(input logic [CFG_DATA_W-1:0] thr_a,
                                 input logic [CFG_DATA_W-1:0] thr_b,
                                 input logic [CFG_DATA_W-1:0] thr_z,
                                 input logic [CFG_DATA_W-1:0] dly_a,
                                 input logic [CFG_DATA_W-1:0] dly_b,
                                 input logic [CFG_DATA_W-1:0] dly_z,
                                 input logic [CFG_DATA_W-1:0] mask);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_register(REG_STAGE_ONE_THR, thr_a);
        write_register(REG_STAGE_TWO_THR, thr_b);
        write_register(REG_ZERO_SEQ_THR, thr_z);
        write_register(REG_STAGE_ONE_DLY, dly_a);
        write_register(REG_STAGE_TWO_DLY, dly_b);
        write_register(REG_ZERO_SEQ_DLY, dly_z);
        write_register(REG_ENABLE_MASK, mask);
        write_register(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
        thr_now[0] = int'(thr_a[THR_W-1:0]);
        thr_now[1] = int'(thr_b[THR_W-1:0]);
        thr_now[2] = int'(thr_z[THR_W-1:0]);
        settings_used++;
    endtask

    task automatic run_directed();
        // all elements are disabled out of reset: flags stay clear
        send_phasor(0, 0, Q12_MAX, Q12_MAX, Q12_MAX, Q12_MAX, Q12_MAX, Q12_MAX);
        send_phasor(3, '1, Q12_MIN, Q12_MIN, Q12_MIN, Q12_MIN, Q12_MIN, Q12_MIN);
        send_phasor(2, 12345, Q12_MIN, Q12_MAX, 0, 0, Q12_MAX, Q12_MIN);
        send_phasor(1, 0, 0, 0, 0, 0, 0, 0);
        program_relay(16'd4096, 16'd3277, 16'd1229, 16'd0, 16'd10, 16'd20, 16'h0FFF);
        // exactly on the stage I threshold: stage II and zero-sequence pick up, stage II times out
        send_phasor(0, 1000, 4096, 0, 0, 0, 0, 0);
        send_phasor(0, 1005, 4096, 0, 0, 0, 0, 0);
        send_phasor(0, 1010, 4096, 0, 0, 0, 0, 0);
        // one count over stage I with no delay trips at once
        send_phasor(1, 1010, 4097, 0, 0, 0, 0, 0);
        // same residual on a section, and a balanced set that has none
        send_phasor(2, 1020, 2000, 0, 0, 0, 0, 0);
        send_phasor(3, 1020, 2000, 0, -1000, 1732, -1000, -1732);
        // drop out, pick up again, then step the clock backwards
        send_phasor(2, 1030, 0, 0, 0, 0, 0, 0);
        send_phasor(2, 1035, 2000, 0, 0, 0, 0, 0);
        send_phasor(2, 1000, 2000, 0, 0, 0, 0, 0);
        // residual above the section limit but below the tie limit
        send_phasor(3, 1040, 1300, 0, 0, 0, 0, 0);
        send_phasor(1, 1040, 1300, 0, 0, 0, 0, 0);
        // largest currents, and the time stamp wrapping through zero
        send_phasor(0, '1, Q12_MIN, Q12_MIN, Q12_MIN, Q12_MIN, Q12_MIN, Q12_MIN);
        send_phasor(1, 0, Q12_MAX, Q12_MAX, Q12_MAX, Q12_MAX, Q12_MAX, Q12_MAX);
        send_phasor(0, 0, Q12_MIN, Q12_MIN, Q12_MIN, Q12_MIN, Q12_MIN, Q12_MIN);
        send_phasor(3, 2000, 0, 0, 0, 0, 0, 0);
        wall_ms = 5000;
    endtask

    task automatic configure_phase(input int phase);
        logic [CFG_DATA_W-1:0] mask;
        case (phase)
            0: begin
                program_relay(16'd4096, 16'd3277, 16'd1229, 16'd0, 16'd0, 16'd0, 16'h0FFF);
                step_max = 3;
            end
            1: begin
                // thresholds at zero and delays at their longest
                program_relay(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'h0FFF);
                step_max = 2000;
            end
            2: begin
                program_relay(16'hFFFF, 16'hFFFF, 16'hFFFF, CFG_DATA_W'($urandom),
                              CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 16'hFFFF);
                step_max = 20000;
            end
            default: begin
                mask = ($urandom_range(0, 1) == 0) ? 16'h0FFF : CFG_DATA_W'($urandom);
                program_relay({1'($urandom), 15'($urandom_range(300, 12000))},
                              {1'($urandom), 15'($urandom_range(300, 12000))},
                              {1'($urandom), 15'($urandom_range(300, 6000))},
                              CFG_DATA_W'($urandom_range(0, 300)),
                              CFG_DATA_W'($urandom_range(0, 300)),
                              CFG_DATA_W'($urandom_range(0, 300)), mask);
                step_max = $urandom_range(5, 120);
            end
        endcase
    endtask

    // runs of items, mostly on one breaker, at a steady fault level, with some noise
    task automatic run_random_phase(input int count);
        int sent;
        int brk;
        int target;
        int scale;
        int shape;
        int spread;
        int a_re;
        int a_im;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 15) == 0) calm_mode = !calm_mode;
            if ($urandom_range(0, 9) == 0) begin
                send_phasor($urandom_range(0, 3), $urandom, rand_q12(), rand_q12(),
                            rand_q12(), rand_q12(), rand_q12(), rand_q12());
                sent++;
            end else begin
                brk    = $urandom_range(0, 3);
                scale  = pick_scale();
                shape  = $urandom_range(0, 2);
                spread = scale / 16 + 1;
                repeat ($urandom_range(2, 12)) begin
                    wall_ms = wall_ms + TIME_W'($urandom_range(0, step_max));
                    if ($urandom_range(0, 31) == 0) begin
                        wall_ms = wall_ms - TIME_W'($urandom_range(1, 5000));
                    end
                    target = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : brk;
                    a_re   = scale + jitter(spread);
                    a_im   = jitter(spread);
                    case (shape)
                        0: send_phasor(target, wall_ms, a_re, a_im, jitter(spread),
                                       jitter(spread), jitter(spread), jitter(spread));
                        1: send_phasor(target, wall_ms, a_re, a_im,
                                       -a_re / 2 + jitter(spread), a_re * 7 / 8,
                                       -a_re / 2, -a_re * 7 / 8 + jitter(spread));
                        default: send_phasor(target, wall_ms, a_re, a_im, jitter(scale),
                                             jitter(scale), jitter(scale), jitter(scale));
                    endcase
                    sent++;
                end
            end
        end
    endtask

    initial begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = calm_mode ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles, stopping", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.breaker_index <= '0;
        in_ch.now_ms        <= '0;
        in_ch.phase_a_real  <= '0;
        in_ch.phase_a_imag  <= '0;
        in_ch.phase_b_real  <= '0;
        in_ch.phase_b_imag  <= '0;
        in_ch.phase_c_real  <= '0;
        in_ch.phase_c_imag  <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.reg_index    <= '0;
        cfg_ch.reg_data     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            configure_phase(phase);
            run_random_phase(PHASE_ITEMS);
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("relay run: %0d phasor items under %0d register settings, %0d results compared",
                 items_sent, settings_used, checked);
        $display("%0d results carried a latched trip, %0d mismatches", trips, fail_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bcor_pkg.sv
rtl/bcor_if.sv
rtl/bcor_ram.sv
rtl/breaker_charging_overcurrent_relay_top.sv
bench/breaker_charging_overcurrent_relay_checker.sv
bench/breaker_charging_overcurrent_relay_top_tb.sv
